>>> hw/rtl/tlb_pkg.sv
// Package for the fully associative TLB: constants, register codes, state
// encoding and the structs passed along the cell chain.
// No dependencies; every other file uses it.
package tlb_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int TLB_SLOTS_DEF  = 16;
    localparam int FRAME_BITS_DEF = 20;

    // Fixed field widths.
    localparam int ADDR_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int SHIFT_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register reset values.
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 4'd6;
    localparam logic               POLICY_RST     = 1'b0;
    localparam logic [COUNT_W-1:0] ENTRIES_RST    = 5'd16;
    localparam logic [STAMP_W-1:0] CLOCK_RST      = 32'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SHIFT     = 2'd0,
        CFG_REPLACE_POLICY = 2'd1,
        CFG_ENTRIES_IN_USE = 2'd2
    } tlb_cfg_t;

    // Request kinds.
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_FILL      = 1'b1;

    // Replacement policies.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } tlb_state_t;

    // Fixed-width part of the search token that walks the cell chain.
    typedef struct packed {
        logic               valid;
        logic               is_fill;
        logic               hit_found;
        logic               same_found;
        logic               empty_found;
        logic               min_have;
        logic [ADDR_W-1:0]  page;
        logic [STAMP_W-1:0] min_stamp;
    } tlb_tok_t;

    // Write-back command broadcast to every cell.
    typedef struct packed {
        logic               en;
        logic               fill;
        logic [STAMP_W-1:0] stamp;
    } tlb_wr_t;

endpackage

>>> hw/rtl/tlb_if.sv
// Valid/ready channel interfaces for TLB requests and responses.
// Depends on tlb_pkg for the field widths.
interface tlb_req_if #(
    parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [tlb_pkg::ADDR_W-1:0]    logical_address;
    logic [tlb_pkg::ADDR_W-1:0]    fill_page;
    logic [FRAME_BITS-1:0]         fill_frame;

    modport source (output valid, output req_type, output logical_address,
                    output fill_page, output fill_frame, input ready);
    modport sink   (input valid, input req_type, input logical_address,
                    input fill_page, input fill_frame, output ready);
endinterface

interface tlb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [tlb_pkg::ADDR_W-1:0]    physical_address;
    logic [tlb_pkg::ADDR_W-1:0]    miss_page;
    logic [tlb_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, output hit, output physical_address,
                    output miss_page, output slot_index, input ready);
    modport sink   (input valid, input hit, input physical_address,
                    input miss_page, input slot_index, output ready);
endinterface

>>> hw/rtl/tlb_cell.sv
// One TLB slot: holds the entry and folds it into the search token that
// passes through on its way down the chain. Depends on tlb_pkg.
module tlb_cell #(
    parameter int TLB_SLOTS  = tlb_pkg::TLB_SLOTS_DEF,
    parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF,
    parameter int IDX        = 0,
    parameter int IDX_W      = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tlb_pkg::COUNT_W-1:0]     entries_in_use,
    input  logic                            replace_policy,
    // Token from the previous cell
    input  tlb_pkg::tlb_tok_t               tok_in,
    input  logic [FRAME_BITS-1:0]           frame_in,
    input  logic [FRAME_BITS-1:0]           hit_frame_in,
    input  logic [IDX_W-1:0]                hit_idx_in,
    input  logic [IDX_W-1:0]                same_idx_in,
    input  logic [IDX_W-1:0]                empty_idx_in,
    input  logic [IDX_W-1:0]                min_idx_in,
    // Token to the next cell
    output tlb_pkg::tlb_tok_t               tok_out,
    output logic [FRAME_BITS-1:0]           frame_out,
    output logic [FRAME_BITS-1:0]           hit_frame_out,
    output logic [IDX_W-1:0]                hit_idx_out,
    output logic [IDX_W-1:0]                same_idx_out,
    output logic [IDX_W-1:0]                empty_idx_out,
    output logic [IDX_W-1:0]                min_idx_out,
    // Write-back
    input  tlb_pkg::tlb_wr_t                wr,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic [tlb_pkg::ADDR_W-1:0]      wr_page,
    input  logic [FRAME_BITS-1:0]           wr_frame
);
    import tlb_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                  valid_reg;
    logic [ADDR_W-1:0]     page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [STAMP_W-1:0]    created_reg;
    logic [STAMP_W-1:0]    used_reg;

    tlb_tok_t              tok_next;
    logic [FRAME_BITS-1:0] hit_frame_next;
    logic [IDX_W-1:0]      hit_idx_next;
    logic [IDX_W-1:0]      same_idx_next;
    logic [IDX_W-1:0]      empty_idx_next;
    logic [IDX_W-1:0]      min_idx_next;

    logic                  active;
    logic                  wr_me;
    logic [STAMP_W-1:0]    stamp;

    assign active = (int'(entries_in_use) > IDX);
    assign wr_me  = wr.en && (wr_idx == MY_IDX);
    assign stamp  = (replace_policy == POLICY_LRU) ? used_reg : created_reg;

    // Fold this slot into the running search results.
    always_comb
    begin
        tok_next       = tok_in;
        hit_frame_next = hit_frame_in;
        hit_idx_next   = hit_idx_in;
        same_idx_next  = same_idx_in;
        empty_idx_next = empty_idx_in;
        min_idx_next   = min_idx_in;
        if (active)
        begin
            if (!tok_in.hit_found && valid_reg && (page_reg == tok_in.page))
            begin
                tok_next.hit_found = 1'b1;
                hit_idx_next       = MY_IDX;
                hit_frame_next     = frame_reg;
            end
            if (!tok_in.same_found && valid_reg && (frame_reg == frame_in))
            begin
                tok_next.same_found = 1'b1;
                same_idx_next       = MY_IDX;
            end
            if (!tok_in.empty_found && !valid_reg)
            begin
                tok_next.empty_found = 1'b1;
                empty_idx_next       = MY_IDX;
            end
            if (!tok_in.min_have || (stamp < tok_in.min_stamp))
            begin
                tok_next.min_have  = 1'b1;
                tok_next.min_stamp = stamp;
                min_idx_next       = MY_IDX;
            end
        end
    end

    // Token stage: the token is cleared on reset so that no stale item walks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out <= '0;
        end
        else
        begin
            tok_out <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_out           <= frame_in;
        hit_frame_out       <= hit_frame_next;
        hit_idx_out         <= hit_idx_next;
        same_idx_out        <= same_idx_next;
        empty_idx_out       <= empty_idx_next;
        min_idx_out         <= min_idx_next;
    end

    // Entry state with its valid bit and stamps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            created_reg <= '0;
            used_reg    <= '0;
        end
        else if (wr_me)
        begin
            used_reg <= wr.stamp;
            if (wr.fill)
            begin
                valid_reg   <= 1'b1;
                created_reg <= wr.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_me && wr.fill)
        begin
            page_reg  <= wr_page;
            frame_reg <= wr_frame;
        end
    end

endmodule

>>> hw/rtl/tlb_fifo_lru_translate.sv
// Top level of the fully associative TLB: configuration registers, the
// controller and the chain of slot cells. Depends on tlb_pkg, tlb_if, tlb_cell.
//
//   Channel   Dir  Handshake          Payload
//   req       in   req.valid/ready    req_type, logical_address, fill_page, fill_frame
//   rsp       out  rsp.valid/ready    hit, physical_address, miss_page, slot_index
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// One request is in flight at a time. The response is registered after the
// search token has visited every cell, one cell per cycle: the result is captured
// as the token leaves the last cell, then the chosen slot is written back as the
// response is registered. The controller then returns to idle, and only there
// is a new request taken.
// A new request is taken while a finished response still waits on rsp; the
// write-back stalls while that response is not taken.
// Reset is asynchronous and empties every slot; there is no clearing pass.
module tlb_fifo_lru_translate #(
    parameter int TLB_SLOTS  = tlb_pkg::TLB_SLOTS_DEF,
    parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlb_pkg::CFG_DATA_W-1:0] cfg_data,
    tlb_req_if.sink                        req,
    tlb_rsp_if.source                      rsp
);
    import tlb_pkg::*;

    localparam int IDX_W = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;

    // Configuration registers.
    logic [SHIFT_W-1:0] page_shift_reg;
    logic               policy_reg;
    logic [COUNT_W-1:0] entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= PAGE_SHIFT_RST;
            policy_reg     <= POLICY_RST;
            entries_reg    <= ENTRIES_RST;
        end
        else if (cfg_we)
        begin
            case (tlb_cfg_t'(cfg_index))
                CFG_PAGE_SHIFT:     page_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_REPLACE_POLICY: policy_reg     <= cfg_data[0];
                CFG_ENTRIES_IN_USE: entries_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Controller state.
    tlb_state_t         state_reg, state_next;
    logic [STAMP_W-1:0] clock_reg;
    logic               out_valid_reg;
    logic               launch_valid_reg;
    logic               in_take;
    logic               commit;
    logic               last_valid;

    // Chain wiring: index 0 is the token launched by the controller.
    tlb_tok_t              tok_c       [TLB_SLOTS+1];
    logic [FRAME_BITS-1:0] frame_c     [TLB_SLOTS+1];
    logic [FRAME_BITS-1:0] hit_frame_c [TLB_SLOTS+1];
    logic [IDX_W-1:0]      hit_idx_c   [TLB_SLOTS+1];
    logic [IDX_W-1:0]      same_idx_c  [TLB_SLOTS+1];
    logic [IDX_W-1:0]      empty_idx_c [TLB_SLOTS+1];
    logic [IDX_W-1:0]      min_idx_c   [TLB_SLOTS+1];

    // Held request fields.
    logic                  is_fill_reg;
    logic [ADDR_W-1:0]     page_reg;
    logic [ADDR_W-1:0]     offset_reg;
    logic [FRAME_BITS-1:0] fill_frame_reg;

    // Captured search results.
    logic                  hit_found_reg;
    logic                  same_found_reg;
    logic                  empty_found_reg;
    logic [FRAME_BITS-1:0] hit_frame_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [IDX_W-1:0]      same_idx_reg;
    logic [IDX_W-1:0]      empty_idx_reg;
    logic [IDX_W-1:0]      min_idx_reg;

    // Write-back command.
    tlb_wr_t               wr;
    logic [IDX_W-1:0]      wr_idx;

    // Response fields computed at commit.
    logic [ADDR_W-1:0]     phys_calc;
    logic [ADDR_W-1:0]     offset_mask;

    assign last_valid = tok_c[TLB_SLOTS].valid;
    assign in_take    = req.valid && req.ready;
    assign commit     = (state_reg == ST_WRITE) && (!out_valid_reg || rsp.ready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req.valid) state_next = ST_SCAN;
            ST_SCAN:  if (last_valid) state_next = ST_WRITE;
            ST_WRITE: if (commit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        req.ready = 1'b0;
        case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_SCAN:  req.ready = 1'b0;
            ST_WRITE: req.ready = 1'b0;
            default:  req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clock_reg <= CLOCK_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                clock_reg <= clock_reg + 1'b1;
            end
        end
    end

    // Split the address and launch the search token on a new transaction.
    assign offset_mask = ~({ADDR_W{1'b1}} << page_shift_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_valid_reg <= 1'b0;
        end
        else
        begin
            launch_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            is_fill_reg    <= (req.req_type == REQ_FILL);
            page_reg       <= (req.req_type == REQ_FILL) ? req.fill_page
                                : (req.logical_address >> page_shift_reg);
            offset_reg     <= req.logical_address & offset_mask;
            fill_frame_reg <= req.fill_frame;
        end
    end

    always_comb
    begin
        tok_c[0].valid       = launch_valid_reg;
        tok_c[0].is_fill     = is_fill_reg;
        tok_c[0].hit_found   = 1'b0;
        tok_c[0].same_found  = 1'b0;
        tok_c[0].empty_found = 1'b0;
        tok_c[0].min_have    = 1'b0;
        tok_c[0].page        = page_reg;
        tok_c[0].min_stamp   = '0;
        frame_c[0]           = fill_frame_reg;
        hit_frame_c[0]       = '0;
        hit_idx_c[0]         = '0;
        same_idx_c[0]        = '0;
        empty_idx_c[0]       = '0;
        min_idx_c[0]         = '0;
    end

    // The row of slot cells.
    for (genvar i = 0; i < TLB_SLOTS; i++)
    begin : g_cell
        tlb_cell #(
            .TLB_SLOTS  (TLB_SLOTS),
            .FRAME_BITS (FRAME_BITS),
            .IDX        (i),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .entries_in_use (entries_reg),
            .replace_policy (policy_reg),
            .tok_in         (tok_c[i]),
            .frame_in       (frame_c[i]),
            .hit_frame_in   (hit_frame_c[i]),
            .hit_idx_in     (hit_idx_c[i]),
            .same_idx_in    (same_idx_c[i]),
            .empty_idx_in   (empty_idx_c[i]),
            .min_idx_in     (min_idx_c[i]),
            .tok_out        (tok_c[i+1]),
            .frame_out      (frame_c[i+1]),
            .hit_frame_out  (hit_frame_c[i+1]),
            .hit_idx_out    (hit_idx_c[i+1]),
            .same_idx_out   (same_idx_c[i+1]),
            .empty_idx_out  (empty_idx_c[i+1]),
            .min_idx_out    (min_idx_c[i+1]),
            .wr             (wr),
            .wr_idx         (wr_idx),
            .wr_page        (page_reg),
            .wr_frame       (fill_frame_reg)
        );
    end

    // Capture the token as it leaves the last cell.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && last_valid)
        begin
            hit_found_reg   <= tok_c[TLB_SLOTS].hit_found;
            same_found_reg  <= tok_c[TLB_SLOTS].same_found;
            empty_found_reg <= tok_c[TLB_SLOTS].empty_found;
            hit_frame_reg   <= hit_frame_c[TLB_SLOTS];
            hit_idx_reg     <= hit_idx_c[TLB_SLOTS];
            same_idx_reg    <= same_idx_c[TLB_SLOTS];
            empty_idx_reg   <= empty_idx_c[TLB_SLOTS];
            min_idx_reg     <= min_idx_c[TLB_SLOTS];
        end
    end

    // Pick the slot to write: for a fill, same frame, then first empty, then the victim; else the hit slot.
    always_comb
    begin
        wr.stamp = clock_reg;
        wr.fill  = is_fill_reg;
        if (is_fill_reg)
        begin
            wr.en = commit && (entries_reg != '0);
            if (same_found_reg)
            begin
                wr_idx = same_idx_reg;
            end
            else if (empty_found_reg)
            begin
                wr_idx = empty_idx_reg;
            end
            else
            begin
                wr_idx = min_idx_reg;
            end
        end
        else
        begin
            wr.en  = commit && hit_found_reg;
            wr_idx = hit_idx_reg;
        end
    end

    assign phys_calc = (ADDR_W'(hit_frame_reg) << page_shift_reg) + offset_reg;

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (is_fill_reg)
            begin
                rsp.hit              <= 1'b0;
                rsp.physical_address <= '0;
                rsp.miss_page        <= '0;
                rsp.slot_index       <= (entries_reg != '0) ? SLOT_W'(wr_idx) : '0;
            end
            else
            begin
                rsp.hit              <= hit_found_reg;
                rsp.physical_address <= hit_found_reg ? phys_calc : '0;
                rsp.miss_page        <= page_reg;
                rsp.slot_index       <= hit_found_reg ? SLOT_W'(hit_idx_reg) : '0;
            end
        end
    end

    assign rsp.valid = out_valid_reg;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the fully associative TLB with FIFO or LRU replacement.
// It drives translate and fill transactions, predicts every response, and checks each field.
// Depends on tlb_pkg, the tlb_req_if and tlb_rsp_if interfaces, and the tlb_fifo_lru_translate RTL.
module testbench;
    import tlb_pkg::*;

    localparam int SLOTS        = TLB_SLOTS_DEF;
    localparam int SETTLE       = 2 * SLOTS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int KNOWN_MAX    = 24;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                      req_type;
        logic [ADDR_W-1:0]         logical_address;
        logic [ADDR_W-1:0]         fill_page;
        logic [FRAME_BITS_DEF-1:0] fill_frame;
    } tlb_request_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] physical_address;
        logic [ADDR_W-1:0] miss_page;
        logic [SLOT_W-1:0] slot_index;
    } tlb_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tlb_req_if req_ch ();
    tlb_rsp_if rsp_ch ();

    tlb_fifo_lru_translate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the TLB contents and its registers.
    logic [SHIFT_W-1:0]        cur_shift = PAGE_SHIFT_RST;
    logic                      cur_policy = POLICY_RST;
    logic [COUNT_W-1:0]        cur_entries = ENTRIES_RST;
    logic                      tlb_valid [SLOTS];
    logic [ADDR_W-1:0]         tlb_page [SLOTS];
    logic [FRAME_BITS_DEF-1:0] tlb_frame [SLOTS];
    logic [STAMP_W-1:0]        tlb_created [SLOTS];
    logic [STAMP_W-1:0]        tlb_used [SLOTS];
    logic [STAMP_W-1:0]        item_clock = CLOCK_RST;

    tlb_request_t      pending_requests [$];
    tlb_result_t       expected_results [$];
    logic [ADDR_W-1:0] known_pages [$];

    idle_mode_t idle_mode = IDLE_NONE;
    logic       req_taken = 1'b0;
    int         holdoff_req = 0;
    int         queued_count = 0;
    int         accepted_count = 0;
    int         fill_count = 0;
    int         hit_count = 0;
    int         phase_count = 0;
    int         err_count = 0;
    int         quiet_cycles = 0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tlb_valid[i] = 1'b0;
            tlb_created[i] = '0;
            tlb_used[i] = '0;
        end
    end

    // Works out the response of one transaction and updates the shadow TLB.
    function automatic tlb_result_t predict_translation(tlb_request_t r);
        tlb_result_t        res;
        int                 n;
        int                 k;
        logic [ADDR_W-1:0]  pg;
        logic [ADDR_W-1:0]  off;
        logic [STAMP_W-1:0] best;
        logic [STAMP_W-1:0] stamp;
        logic [63:0]        wide;
        res = '0;
        n = (cur_entries > SLOTS) ? SLOTS : int'(cur_entries);
        if (r.req_type == REQ_TRANSLATE)
        begin
            pg = r.logical_address >> cur_shift;
            off = r.logical_address & ((32'd1 << cur_shift) - 32'd1);
            res.miss_page = pg;
            for (int i = 0; i < n; i++)
            begin
                if (!res.hit && tlb_valid[i] && tlb_page[i] == pg)
                begin
                    tlb_used[i] = item_clock;
                    wide = (64'(tlb_frame[i]) << cur_shift) + 64'(off);
                    res.hit = 1'b1;
                    res.physical_address = wide[ADDR_W-1:0];
                    res.slot_index = 4'(i);
                end
            end
            if (res.hit)
                hit_count++;
        end
        else if (n > 0)
        begin
            // A slot with the same frame wins, then the first empty one, then the oldest stamp.
            k = -1;
            for (int i = 0; i < n; i++)
                if (k < 0 && tlb_valid[i] && tlb_frame[i] == r.fill_frame)
                    k = i;
            for (int i = 0; i < n; i++)
                if (k < 0 && !tlb_valid[i])
                    k = i;
            if (k < 0)
            begin
                k = 0;
                best = (cur_policy == POLICY_LRU) ? tlb_used[0] : tlb_created[0];
                for (int i = 1; i < n; i++)
                begin
                    stamp = (cur_policy == POLICY_LRU) ? tlb_used[i] : tlb_created[i];
                    if (stamp < best)
                    begin
                        best = stamp;
                        k = i;
                    end
                end
            end
            tlb_valid[k] = 1'b1;
            tlb_page[k] = r.fill_page;
            tlb_frame[k] = r.fill_frame;
            tlb_created[k] = item_clock;
            tlb_used[k] = item_clock;
            res.slot_index = 4'(k);
        end
        item_clock = item_clock + 32'd1;
        return res;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result(tlb_result_t got);
        tlb_result_t want;
        if (expected_results.size() == 0)
        begin
            report_error($sformatf("response with nothing expected: %p", got));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.hit !== want.hit)
                report_error($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.physical_address !== want.physical_address)
                report_error($sformatf("physical_address %h, expected %h",
                                       got.physical_address, want.physical_address));
            if (got.miss_page !== want.miss_page)
                report_error($sformatf("miss_page %h, expected %h",
                                       got.miss_page, want.miss_page));
            if (got.slot_index !== want.slot_index)
                report_error($sformatf("slot_index %0d, expected %0d",
                                       got.slot_index, want.slot_index));
        end
    endtask

    function automatic bit draw_idle(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Request driver: holds each transaction until it is taken.
    always @(negedge clk)
    begin : drive_requests
        tlb_request_t nxt;
        int           pct;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            pct = (idle_mode == IDLE_SEND) ? 70 : (idle_mode == IDLE_BOTH) ? 27 : 0;
            if (pending_requests.size() != 0 && !draw_idle(pct))
            begin
                nxt = pending_requests.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.req_type <= nxt.req_type;
                req_ch.logical_address <= nxt.logical_address;
                req_ch.fill_page <= nxt.fill_page;
                req_ch.fill_frame <= nxt.fill_frame;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin : drive_ready
        int   hold_left;
        int   holdoff_ack;
        int   pct;
        logic rdy;
        if (holdoff_ack != holdoff_req)
        begin
            hold_left = HOLD_CYCLES;
            holdoff_ack = holdoff_req;
        end
        if (hold_left > 0)
        begin
            rdy = 1'b0;
            hold_left--;
        end
        else
        begin
            pct = (idle_mode == IDLE_RECV) ? 70 : (idle_mode == IDLE_BOTH) ? 27 : 0;
            rdy = !draw_idle(pct);
        end
        rsp_ch.ready <= rdy;
    end

    // Monitor: checks responses, then predicts for accepted requests.
    always @(posedge clk)
    begin : watch_channels
        tlb_request_t r;
        tlb_result_t  got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.hit = rsp_ch.hit;
                got.physical_address = rsp_ch.physical_address;
                got.miss_page = rsp_ch.miss_page;
                got.slot_index = rsp_ch.slot_index;
                check_result(got);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.req_type = req_ch.req_type;
                r.logical_address = req_ch.logical_address;
                r.fill_page = req_ch.fill_page;
                r.fill_frame = req_ch.fill_frame;
                expected_results.push_back(predict_translation(r));
                accepted_count++;
            end
            req_taken <= req_ch.valid && req_ch.ready;
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic tlb_request_t make_translate(logic [ADDR_W-1:0] addr);
        tlb_request_t r;
        r.req_type = REQ_TRANSLATE;
        r.logical_address = addr;
        r.fill_page = $urandom;
        r.fill_frame = FRAME_BITS_DEF'($urandom);
        return r;
    endfunction

    function automatic tlb_request_t make_fill(logic [ADDR_W-1:0] pg,
                                               logic [FRAME_BITS_DEF-1:0] fr);
        tlb_request_t r;
        r.req_type = REQ_FILL;
        r.logical_address = $urandom;
        r.fill_page = pg;
        r.fill_frame = fr;
        return r;
    endfunction

    task automatic add_request(tlb_request_t r);
        if (r.req_type == REQ_FILL)
        begin
            fill_count++;
            known_pages.push_back(r.fill_page);
            if (known_pages.size() > KNOWN_MAX)
                void'(known_pages.pop_front());
        end
        pending_requests.push_back(r);
        queued_count++;
    endtask

    // Mostly translations of pages already filled, with random offsets; fills
    // reuse a small frame pool so that same-frame overwrites happen often.
    task automatic add_random_request();
        logic [ADDR_W-1:0]         pg;
        logic [ADDR_W-1:0]         mask;
        logic [FRAME_BITS_DEF-1:0] fr;
        int                        pick;
        mask = (32'd1 << cur_shift) - 32'd1;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            if (known_pages.size() != 0 && $urandom_range(99) < 70)
            begin
                pg = known_pages[$urandom_range(known_pages.size() - 1)];
                add_request(make_translate((pg << cur_shift) | ($urandom & mask)));
            end
            else
            begin
                add_request(make_translate($urandom));
            end
        end
        else
        begin
            pick = $urandom_range(99);
            if (known_pages.size() != 0 && pick < 15)
                pg = known_pages[$urandom_range(known_pages.size() - 1)];
            else if (pick < 25)
                pg = $urandom;
            else
                pg = $urandom >> cur_shift;
            if ($urandom_range(99) < 40)
                fr = FRAME_BITS_DEF'($urandom_range(15));
            else
                fr = FRAME_BITS_DEF'($urandom);
            add_request(make_fill(pg, fr));
        end
    endtask

    task automatic write_reg(tlb_cfg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            CFG_PAGE_SHIFT:     cur_shift = val[SHIFT_W-1:0];
            CFG_REPLACE_POLICY: cur_policy = val[0];
            CFG_ENTRIES_IN_USE: cur_entries = val;
            default:            ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Waits until every request is taken and every response checked, then
    // lets the last write-back finish.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(logic [SHIFT_W-1:0] shift, logic policy,
                             logic [COUNT_W-1:0] entries, idle_mode_t mode,
                             int count, bit holdoff);
        wait_drained();
        write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_REPLACE_POLICY, CFG_DATA_W'(policy));
        write_reg(CFG_ENTRIES_IN_USE, entries);
        idle_mode = mode;
        phase_count++;
        for (int i = 0; i < count; i++)
            add_random_request();
        if (holdoff)
            holdoff_req++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PAGE_SHIFT;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_TRANSLATE;
        req_ch.logical_address = '0;
        req_ch.fill_page = '0;
        req_ch.fill_frame = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset settings: 64-byte pages, FIFO, 16 slots.
        phase_count++;
        add_request(make_translate(32'h0000_0000));
        add_request(make_translate(32'hFFFF_FFFF));
        add_request(make_fill(32'h0000_0000, 20'h00000));
        add_request(make_fill(32'h03FF_FFFF, 20'hFFFFF));
        add_request(make_translate(32'h0000_003F));
        add_request(make_translate(32'hFFFF_FFFF));
        // Same frame overwrites slot 1; then the same page lands in a second slot.
        add_request(make_fill(32'h0000_0005, 20'hFFFFF));
        add_request(make_fill(32'h0000_0005, 20'h00007));
        add_request(make_translate(32'h0000_0141));
        add_request(make_fill(32'hFFFF_FFFF, 20'h00001));
        for (int i = 0; i < 12; i++)
            add_request(make_fill(32'(100 + i), FRAME_BITS_DEF'(100 + i)));
        // The TLB is full now, so this fill evicts the oldest entry.
        add_request(make_fill(32'd200, 20'd200));
        add_request(make_translate(32'h0000_0000));

        // Random phases over the register settings and idling patterns.
        run_phase(4'd12, POLICY_LRU,  5'd16, IDLE_NONE, 200, 1'b0);
        run_phase(4'd0,  POLICY_FIFO, 5'd4,  IDLE_SEND, 200, 1'b0);
        run_phase(4'd15, POLICY_LRU,  5'd31, IDLE_RECV, 200, 1'b0);
        run_phase(4'd6,  POLICY_LRU,  5'd0,  IDLE_BOTH, 60,  1'b0);
        run_phase(4'd8,  POLICY_FIFO, 5'd1,  IDLE_BOTH, 150, 1'b0);
        run_phase(4'd4,  POLICY_LRU,  5'd8,  IDLE_RECV, 150, 1'b0);
        run_phase(4'd12, POLICY_FIFO, 5'd16, IDLE_SEND, 200, 1'b0);
        run_phase(4'd2,  POLICY_LRU,  5'd16, IDLE_NONE, 140, 1'b1);
        wait_drained();

        $display("Run covered %0d transactions: %0d fills, %0d translations, %0d hits.",
                 accepted_count, fill_count, accepted_count - fill_count, hit_count);
        $display("Settings spanned %0d phases: page shifts 0 to 15, FIFO and LRU, 0 to 31 slots.",
                 phase_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
